@@ hw/rtl/qrv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qrv_pkg;

    localparam int unsigned CORDIC_STAGES_DEF = 32;
    localparam int unsigned CORDIC_PRESHIFT   = 20;
    localparam logic [30:0] THR_RESET         = 31'd1074;
    localparam logic [30:0] THETA_MAX         = 31'd1686629714;
    localparam logic [63:0] PI_4_Q60          = 64'h0C90FDAA22168C23;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               small_angle;
    } rot_t;

    // per-item sideband after block scaling
    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [3:0][30:0] av;
    } side_t;

    typedef struct packed {
        side_t       sd;
        logic [31:0] r;
        logic [31:0] vr;
        logic [62:0] thr_prod;
    } cside_t;

    typedef struct packed {
        logic       zero;
        logic       small_br;
        logic [2:0] neg;
    } dside_t;

    // atan(2^-i) in Q.60 by the alternating series, evaluated at elaboration
    function automatic logic [63:0] atan_q60(input int unsigned i);
        logic [63:0] acc;
        logic [63:0] term;
        int unsigned sh;
        logic        done;
        acc  = '0;
        done = 1'b0;
        if (i == 0) begin
            acc = PI_4_Q60;
            done = 1'b1;
        end
        for (int unsigned k = 0; k < 64; k++) begin
            sh = i * (2 * k + 1);
            if (!done && sh > 60) begin
                done = 1'b1;
            end
            if (!done) begin
                term = (64'd1 << (60 - sh)) / 64'(2 * k + 1);
                if (k[0]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/quaternion_to_rotation_vector_unit.sv @@
// Quaternion to rotation vector unit (logarithm map of SO(3)).
// Input channel s_valid/s_ready/s_data carries one quaternion (w,x,y,z) in
// signed Q1.30 per transfer; output channel m_valid/m_ready/m_data carries the
// rotation vector in signed Q2.29 and the small_angle flag.
// cfg_valid/cfg_ready/cfg_data writes small_angle_threshold (Q1.30); cfg_ready
// is always high. Write it only while no item is in flight.
// Throughput: one item per cycle, unless the full output queue holds the pipeline.
// The pipeline is built from the 32-stage square root, the CORDIC stages and
// the 31-stage divider, plus block scaling, squaring and the output queue.
// Reset clears all valid bits and loads the threshold with 1074.
// A two-entry output queue sits behind the pipeline: s_ready stays high while
// one result waits; only when both entries are full and m_ready is low does
// the whole pipeline hold, losing and repeating nothing.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_rotation_vector_unit #(
    parameter int unsigned CORDIC_STAGES = qrv_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire qrv_pkg::quat_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output qrv_pkg::rot_t        m_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [30:0]     cfg_data
);
    import qrv_pkg::*;

    localparam int unsigned SQ_N  = 32;
    localparam int unsigned DIV_N = 31;
    localparam int unsigned XY_W  = 56;

    logic        en;
    logic [30:0] thr_reg;

    logic [3:0][31:0] raw_in;
    logic [3:0][31:0] mag1_reg, mag2_reg, mag3_reg;
    logic [2:0]       neg1_reg, neg2_reg, neg3_reg;
    logic [31:0]      m2_reg;
    logic             rsh3_reg, zero3_reg;
    logic [4:0]       lsh3_reg, lsh3_next;
    side_t            sd4_reg, sd5_reg, sd6_reg;
    logic [3:0][60:0] sq5_reg;
    logic [61:0]      p12_6_reg, p30_6_reg;
    logic [60:0]      sq3_6_reg;
    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    logic [62:0] sqrem_reg [SQ_N+1][2];
    logic [62:0] sqrem_next [SQ_N+1][2];
    logic [31:0] sqres_reg [SQ_N+1][2];
    logic [31:0] sqres_next [SQ_N+1][2];
    side_t       sqsd_reg [SQ_N+1];
    side_t       sqsd_next [SQ_N+1];
    logic [SQ_N:0] sqv_reg;

    logic signed [XY_W-1:0] cx_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] cx_next [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] cy_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] cy_next [CORDIC_STAGES+1];
    logic signed [63:0]     cz_reg [CORDIC_STAGES+1];
    logic signed [63:0]     cz_next [CORDIC_STAGES+1];
    cside_t                 ccs_reg [CORDIC_STAGES+1];
    cside_t                 ccs_next [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0] cv_reg;
    logic signed [63:0]     atan_c [CORDIC_STAGES];

    logic [30:0] theta_reg, theta_next;
    logic        small_th_reg, small_th_next;
    logic [31:0] div_th_reg, div_mu_reg;
    side_t       sd_th_reg, sd_mu_reg;
    logic        v_th_reg, v_mu_reg, small_mu_reg;
    logic [2:0][61:0] prod_mu_reg;

    logic [61:0] drem_reg [DIV_N+1][3];
    logic [61:0] drem_next [DIV_N+1][3];
    logic [30:0] dq_reg [DIV_N+1][3];
    logic [30:0] dq_next [DIV_N+1][3];
    logic [31:0] ddiv_reg [DIV_N+1];
    logic [31:0] ddiv_next [DIV_N+1];
    dside_t      dsd_reg [DIV_N+1];
    dside_t      dsd_next [DIV_N+1];
    logic [DIV_N:0] dv_reg;

    rot_t fn_data_reg, fn_data_next;
    logic fn_v_reg;

    rot_t q0_data_reg, q0_data_next, q1_data_reg, q1_data_next;
    logic q0_valid_reg, q0_valid_next, q1_valid_reg, q1_valid_next;
    logic push, pop;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_atan
        localparam logic [63:0] ANG = atan_q60(g);
        assign atan_c[g] = ANG;
    end

    assign en        = !(q0_valid_reg && q1_valid_reg) || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign raw_in    = {s_data.quat_z, s_data.quat_y, s_data.quat_x, s_data.quat_w};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // magnitude, max, scaling shift
    always_comb begin
        lsh3_next = '0;
        for (int b = 0; b < 29; b++) begin
            if (m2_reg[b]) begin
                lsh3_next = 5'(29 - b);
            end
        end
        if (m2_reg[31:29] != 3'd0) begin
            lsh3_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                mag1_reg[i] <= raw_in[i][31] ? (~raw_in[i] + 32'd1) : raw_in[i];
            end
            for (int i = 1; i < 4; i++) begin
                neg1_reg[i-1] <= raw_in[i][31] ^ raw_in[0][31];
            end

            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            m2_reg   <= ((mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1]) >
                        ((mag1_reg[2] > mag1_reg[3]) ? mag1_reg[2] : mag1_reg[3]) ?
                        ((mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1]) :
                        ((mag1_reg[2] > mag1_reg[3]) ? mag1_reg[2] : mag1_reg[3]);

            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            rsh3_reg  <= m2_reg[31] || (m2_reg[30] && (m2_reg[29:0] != 30'd0));
            lsh3_reg  <= lsh3_next;
            zero3_reg <= (m2_reg == 32'd0);

            sd4_reg.zero <= zero3_reg;
            sd4_reg.neg  <= neg3_reg;
            for (int i = 0; i < 4; i++) begin
                sd4_reg.av[i] <= rsh3_reg ? mag3_reg[i][31:1] : 31'(mag3_reg[i] << lsh3_reg);
            end

            sd5_reg <= sd4_reg;
            for (int i = 0; i < 4; i++) begin
                sq5_reg[i] <= 61'({31'd0, sd4_reg.av[i]} * {31'd0, sd4_reg.av[i]});
            end

            sd6_reg   <= sd5_reg;
            p12_6_reg <= {1'b0, sq5_reg[1]} + {1'b0, sq5_reg[2]};
            p30_6_reg <= {1'b0, sq5_reg[3]} + {1'b0, sq5_reg[0]};
            sq3_6_reg <= sq5_reg[3];
        end
    end

    // integer square roots of the full and vector-part sums
    always_comb begin
        logic [63:0] trial;
        trial = '0;
        sqrem_next[0][0] = {1'b0, p12_6_reg} + {1'b0, p30_6_reg};
        sqrem_next[0][1] = {1'b0, p12_6_reg} + {2'b0, sq3_6_reg};
        sqres_next[0][0] = '0;
        sqres_next[0][1] = '0;
        sqsd_next[0]     = sd6_reg;
        for (int j = 0; j < SQ_N; j++) begin
            for (int l = 0; l < 2; l++) begin
                trial = ({32'd0, sqres_reg[j][l]} << (SQ_N - j)) |
                        (64'd1 << (2 * (SQ_N - 1 - j)));
                if ({1'b0, sqrem_reg[j][l]} >= trial) begin
                    sqrem_next[j+1][l] = sqrem_reg[j][l] - trial[62:0];
                    sqres_next[j+1][l] = sqres_reg[j][l] | (32'd1 << (SQ_N - 1 - j));
                end else begin
                    sqrem_next[j+1][l] = sqrem_reg[j][l];
                    sqres_next[j+1][l] = sqres_reg[j][l];
                end
            end
            sqsd_next[j+1] = sqsd_reg[j];
        end
    end

    // vectoring cordic on (|w|, |v|)
    always_comb begin
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic [62:0]            tp;
        tp = {32'd0, thr_reg} * {31'd0, sqres_reg[SQ_N][0]};
        cx_next[0] = XY_W'(sqsd_reg[SQ_N].av[0]) << CORDIC_PRESHIFT;
        cy_next[0] = XY_W'(sqres_reg[SQ_N][1]) << CORDIC_PRESHIFT;
        cz_next[0] = '0;
        ccs_next[0].sd       = sqsd_reg[SQ_N];
        ccs_next[0].r        = sqres_reg[SQ_N][0];
        ccs_next[0].vr       = sqres_reg[SQ_N][1];
        ccs_next[0].thr_prod = tp;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = cy_reg[i] >>> i;
            dy = cx_reg[i] >>> i;
            if (!cy_reg[i][XY_W-1]) begin
                cx_next[i+1] = cx_reg[i] + dx;
                cy_next[i+1] = cy_reg[i] - dy;
                cz_next[i+1] = cz_reg[i] + atan_c[i];
            end else begin
                cx_next[i+1] = cx_reg[i] - dx;
                cy_next[i+1] = cy_reg[i] + dy;
                cz_next[i+1] = cz_reg[i] - atan_c[i];
            end
            ccs_next[i+1] = ccs_reg[i];
        end
    end

    // angle rounding and branch select
    always_comb begin
        logic [63:0] zr;
        logic [63:0] tr;
        logic [62:0] lhs;
        cside_t      cs;
        cs  = ccs_reg[CORDIC_STAGES];
        zr  = cz_reg[CORDIC_STAGES] + 64'd536870912;
        tr  = zr >> 30;
        lhs = ({31'd0, cs.vr} << 30) + {32'd0, cs.r[31:1]};
        if (cz_reg[CORDIC_STAGES] <= 0) begin
            theta_next = '0;
        end else if (tr > {33'd0, THETA_MAX}) begin
            theta_next = THETA_MAX;
        end else begin
            theta_next = tr[30:0];
        end
        small_th_next = (cs.vr == 32'd0) || (lhs < cs.thr_prod);
    end

    // numerators and long division
    always_comb begin
        logic [61:0] trial;
        trial = '0;
        for (int i = 0; i < 3; i++) begin
            drem_next[0][i] = (small_mu_reg ? {1'b0, sd_mu_reg.av[i+1], 30'd0} :
                               prod_mu_reg[i]) + {31'd0, div_mu_reg[31:1]};
            dq_next[0][i]   = '0;
        end
        ddiv_next[0]         = div_mu_reg;
        dsd_next[0].zero     = sd_mu_reg.zero;
        dsd_next[0].small_br = small_mu_reg;
        dsd_next[0].neg      = sd_mu_reg.neg;
        for (int j = 0; j < DIV_N; j++) begin
            for (int i = 0; i < 3; i++) begin
                trial = {30'd0, ddiv_reg[j]} << (DIV_N - 1 - j);
                if (drem_reg[j][i] >= trial) begin
                    drem_next[j+1][i] = drem_reg[j][i] - trial;
                    dq_next[j+1][i]   = dq_reg[j][i] | (31'd1 << (DIV_N - 1 - j));
                end else begin
                    drem_next[j+1][i] = drem_reg[j][i];
                    dq_next[j+1][i]   = dq_reg[j][i];
                end
            end
            ddiv_next[j+1] = ddiv_reg[j];
            dsd_next[j+1]  = dsd_reg[j];
        end
    end

    // sign and zero handling
    always_comb begin
        logic [2:0][31:0] val;
        logic [31:0]      mag;
        dside_t           ds;
        ds = dsd_reg[DIV_N];
        for (int i = 0; i < 3; i++) begin
            mag    = {1'b0, dq_reg[DIV_N][i]};
            val[i] = ds.zero ? 32'd0 : (ds.neg[i] ? (~mag + 32'd1) : mag);
        end
        fn_data_next.rot_x       = val[0];
        fn_data_next.rot_y       = val[1];
        fn_data_next.rot_z       = val[2];
        fn_data_next.small_angle = ds.zero || ds.small_br;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqrem_reg <= sqrem_next;
            sqres_reg <= sqres_next;
            sqsd_reg  <= sqsd_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            cz_reg    <= cz_next;
            ccs_reg   <= ccs_next;

            theta_reg    <= theta_next;
            small_th_reg <= small_th_next;
            div_th_reg   <= small_th_next ? ccs_reg[CORDIC_STAGES].r :
                                            ccs_reg[CORDIC_STAGES].vr;
            sd_th_reg    <= ccs_reg[CORDIC_STAGES].sd;

            for (int i = 0; i < 3; i++) begin
                prod_mu_reg[i] <= {31'd0, theta_reg} * {31'd0, sd_th_reg.av[i+1]};
            end
            small_mu_reg <= small_th_reg;
            div_mu_reg   <= div_th_reg;
            sd_mu_reg    <= sd_th_reg;

            drem_reg <= drem_next;
            dq_reg   <= dq_next;
            ddiv_reg <= ddiv_next;
            dsd_reg  <= dsd_next;

            fn_data_reg <= fn_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            sqv_reg  <= '0;
            cv_reg   <= '0;
            v_th_reg <= 1'b0;
            v_mu_reg <= 1'b0;
            dv_reg   <= '0;
            fn_v_reg <= 1'b0;
        end else if (en) begin
            v1_reg   <= s_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            sqv_reg  <= {sqv_reg[SQ_N-1:0], v6_reg};
            cv_reg   <= {cv_reg[CORDIC_STAGES-1:0], sqv_reg[SQ_N]};
            v_th_reg <= cv_reg[CORDIC_STAGES];
            v_mu_reg <= v_th_reg;
            dv_reg   <= {dv_reg[DIV_N-1:0], v_mu_reg};
            fn_v_reg <= dv_reg[DIV_N];
        end
    end

    // two-entry output queue
    assign pop  = q0_valid_reg && m_ready;
    assign push = en && fn_v_reg;

    always_comb begin
        q0_valid_next = q0_valid_reg;
        q1_valid_next = q1_valid_reg;
        q0_data_next  = q0_data_reg;
        q1_data_next  = q1_data_reg;
        if (pop) begin
            q0_valid_next = q1_valid_reg;
            q0_data_next  = q1_data_reg;
            q1_valid_next = 1'b0;
        end
        if (push) begin
            if (!q0_valid_next) begin
                q0_valid_next = 1'b1;
                q0_data_next  = fn_data_reg;
            end else begin
                q1_valid_next = 1'b1;
                q1_data_next  = fn_data_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q0_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
        end else begin
            q0_valid_reg <= q0_valid_next;
            q1_valid_reg <= q1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_data_reg <= q0_data_next;
        q1_data_reg <= q1_data_next;
    end

    assign m_valid = q0_valid_reg;
    assign m_data  = q0_data_reg;

    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        q1_valid_reg |-> q0_valid_reg)
        else $error("second queue entry valid without head");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> !q1_valid_reg)
        else $error("transfer into full output queue");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && fn_v_reg) |=> (fn_v_reg && $stable(fn_data_reg)))
        else $error("last pipeline stage changed during stall");

endmodule

`default_nettype wire
